// ===== hw/rtl/tkf_pkg.sv =====
// Shared types, constants and helpers for the tilt-angle Kalman fusion block.
// Used by tkf_div and tilt_angle_kalman_fusion; depends on nothing else.
package tkf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIV_A_W   = 48;                  // dividend width
	localparam int DIV_N_W   = 52;                  // rounded numerator magnitude
	localparam int DIV_R_W   = 34;                  // remainder / divisor width
	localparam int DIV_CNT_W = 6;

	// accelerometer: 180 deg over 16384 counts, exact at these fraction bits
	localparam logic signed [10:0] MEAS_SCALE = 11'sd720;
	localparam logic signed [31:0] TRIKE_ANGLE = 32'sd25 <<< FRAC_BITS;
	// gyro: 0.048 deg/s per count is 6/125, so the rate is 3g * 2^17 / 125;
	// split 3g = 125a + b and divide both parts by reciprocal multiplies
	localparam logic [18:0] RATE_OFS   = 19'd196625;    // 125 * 1573, keeps 3g + ofs positive
	localparam logic [12:0] RATE_OFS_Q = 13'd1573;
	localparam logic [19:0] RECIP_A    = 20'd536871;    // ceil(2^26 / 125)
	localparam logic [24:0] RECIP_B    = 25'd17179870;  // ceil(2^31 / 125)
	localparam logic [23:0] RATE_HALF  = 24'd62;
	localparam logic signed [65:0] MUL_HALF = 66'sd32768;
	localparam logic signed [31:0] ONE_Q   = 32'sd65536;

	typedef enum logic [3:0] {
		CFG_ANGLE_Q  = 4'd0,
		CFG_BIAS_Q   = 4'd1,
		CFG_MEAS_R   = 4'd2,
		CFG_DT       = 4'd3,
		CFG_ACC_OFS  = 4'd4,
		CFG_GYR_OFS  = 4'd5,
		CFG_MODE     = 4'd6,
		CFG_LEAN     = 4'd7
	} cfg_idx_t;

	// multiply-accumulate steps of one item, in issue order
	typedef enum logic [3:0] {
		OP_ANG_PRED = 4'd0,
		OP_P00_PRED = 4'd1,
		OP_P01_PRED = 4'd2,
		OP_P10_PRED = 4'd3,
		OP_P11_PRED = 4'd4,
		OP_P00_UPD  = 4'd5,
		OP_P01_UPD  = 4'd6,
		OP_P10_UPD  = 4'd7,
		OP_P11_UPD  = 4'd8,
		OP_ANG_UPD  = 4'd9,
		OP_BIAS_UPD = 4'd10
	} op_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_RATE0 = 8'b00000010,
		S_RATE1 = 8'b00000100,
		S_MUL   = 8'b00001000,
		S_ACC   = 8'b00010000,
		S_PREPK = 8'b00100000,
		S_GAIN0 = 8'b01000000,
		S_GAIN1 = 8'b10000000
	} state_t;

	typedef struct packed {
		logic done;
		logic busy;
	} div_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
		if (x > 68'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -68'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

endpackage

// ===== hw/rtl/tkf_div.sv =====
// Restoring serial divider: round-to-nearest (ties up) of a / b, saturated to 32 bits.
// One quotient bit per cycle. Depends on tkf_pkg.
module tkf_div import tkf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [DIV_A_W-1:0]  a,
	input  logic signed [31:0]         b,
	output div_stat_t                  stat,
	output logic signed [31:0]         quot
);

	logic                       busy_q, fin_q, done_q, neg_q;
	logic [DIV_CNT_W-1:0]       cnt_q;
	logic [DIV_N_W-1:0]         num_q;
	logic [DIV_R_W-1:0]         rem_q, den_q;
	logic signed [DIV_A_W:0]    an;
	logic signed [32:0]         bn;
	logic signed [DIV_N_W-1:0]  nn;
	logic [DIV_R_W:0]           trial;
	logic signed [DIV_N_W:0]    qs;

	// fold the sign of b into a, then form 2a+b over 2b
	always_comb begin
		an = (b < 0) ? -(DIV_A_W+1)'(a) : (DIV_A_W+1)'(a);
		bn = (b < 0) ? -33'(b) : 33'(b);
		nn = (DIV_N_W)'(an) * 2 + (DIV_N_W)'(bn);
		trial = {rem_q, num_q[DIV_N_W-1]} - {1'b0, den_q};
		qs = neg_q ? -$signed({1'b0, num_q}) - $signed({{DIV_N_W{1'b0}}, rem_q != '0})
		           : $signed({1'b0, num_q});
	end

	// advance one quotient bit a cycle, finish with sign and saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q && !fin_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			neg_q <= nn < 0;
			num_q <= (nn < 0) ? DIV_N_W'(-nn) : DIV_N_W'(nn);
			rem_q <= '0;
			den_q <= {bn, 1'b0};
		end else if (busy_q && !fin_q) begin
			if (!trial[DIV_R_W]) begin
				rem_q <= trial[DIV_R_W-1:0];
				num_q <= {num_q[DIV_N_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_R_W-2:0], num_q[DIV_N_W-1]};
				num_q <= {num_q[DIV_N_W-2:0], 1'b0};
			end
		end else if (fin_q) begin
			quot <= sat32(68'(qs));
		end
	end

	assign stat.done = done_q;
	assign stat.busy = busy_q;

endmodule

// ===== hw/rtl/tilt_angle_kalman_fusion.sv =====
// Tilt-angle fusion top level: accelerometer/gyro scaling and a two-state Kalman filter.
// Uses tkf_pkg and the serial divider tkf_div.
//
// One word in gives one word out. Each item passes through gyro scaling by reciprocal
// multiplies, five predict steps on one shared 33x33 multiplier, a step to set up the gains,
// two serial divisions for the gains, six update steps, and a hand-over of the result.
// When the innovation variance is zero the divisions are skipped. in_stall is low only when
// the sequencer is idle and no result waits for the output register; a finished result
// waits in the output register while the next word is accepted.
module tilt_angle_kalman_fusion import tkf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] fused_angle,
	output logic signed [31:0] angle_rate
);

	state_t              state_q;
	op_t                 op_q;
	logic [16:0]         aq_q, bq_q, dt_q;
	logic [22:0]         r_q;
	logic signed [15:0]  acc_ofs_q, gyr_ofs_q;
	logic                mode_q;
	logic signed [23:0]  lean_q;
	logic signed [31:0]  ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [31:0]  meas_q, rate_q, err_q, e_q, t0_q, t1_q, k0_q, k1_q;
	logic signed [65:0]  prod_q;
	logic                out_valid_q;
	logic                pend_q;
	logic [18:0]         hp_q;
	logic [12:0]         qa_q;
	logic [23:0]         y_q;

	logic signed [16:0]  d, g;
	logic signed [31:0]  meas_n, e_n, msat, base, res;
	logic signed [32:0]  opa, opb;
	logic signed [65:0]  rnd;
	logic                sub;
	logic                div_start;
	logic signed [DIV_A_W-1:0] div_a;
	logic signed [31:0]  div_b, div_q;
	div_stat_t           div_st;
	logic                in_acc;
	logic [18:0]         hp_n;
	logic [38:0]         pa;
	logic [12:0]         qa_n;
	logic [6:0]          rb_n;
	logic [48:0]         pb;
	logic [17:0]         q2_n;
	logic signed [31:0]  rate_n;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || pend_q;

	// input scaling
	always_comb begin
		d = 17'(accel_z) - 17'(acc_ofs_q);
		g = 17'(gyro_y) - 17'(gyr_ofs_q);
		meas_n = sat32(68'(d) * 68'(MEAS_SCALE)
		               + (mode_q ? 68'(TRIKE_ANGLE) : 68'(lean_q)));
		e_n = sat32(68'($signed({1'b0, r_q})) + 68'(p00_q));
	end

	// gyro rate: split 3g into 125a + b, then round the remainder part
	always_comb begin
		hp_n   = 19'(20'(g) * 20'sd3 + 20'(RATE_OFS));
		pa     = 39'(hp_q) * 39'(RECIP_A);
		qa_n   = pa[38:26];
		rb_n   = 7'(hp_q - 19'(qa_n) * 19'd125);
		pb     = 49'(y_q) * 49'(RECIP_B);
		q2_n   = pb[48:31];
		rate_n = ((32'(qa_q) - 32'(RATE_OFS_Q)) << (FRAC_BITS + 1)) + 32'(q2_n);
	end

	// divider operand selection
	always_comb begin
		div_start = 1'b0;
		div_a = {p00_q, {FRAC_BITS{1'b0}}};
		div_b = e_n;
		if (state_q == S_PREPK) begin
			div_start = e_n != 0;
		end else if (state_q == S_GAIN0) begin
			div_start = div_st.done;
			div_a = {p10_q, {FRAC_BITS{1'b0}}};
			div_b = e_q;
		end
	end

	tkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.b      (div_b),
		.stat   (div_st),
		.quot   (div_q)
	);

	// multiplier operands and accumulate target per step
	always_comb begin
		opa  = '0;
		opb  = $signed({16'b0, dt_q});
		base = ang_q;
		sub  = 1'b0;
		unique case (op_q)
			OP_ANG_PRED: begin
				opa = 33'(sat32(68'(rate_q) - 68'(bias_q)));
			end
			OP_P00_PRED: begin
				opa = 33'(sat32(68'($signed({1'b0, aq_q})) - 68'(p01_q) - 68'(p10_q)));
				base = p00_q;
			end
			OP_P01_PRED: begin
				opa = -33'(p11_q);
				base = p01_q;
			end
			OP_P10_PRED: begin
				opa = -33'(p11_q);
				base = p10_q;
			end
			OP_P11_PRED: begin
				opa = $signed({16'b0, bq_q});
				base = p11_q;
			end
			OP_P00_UPD: begin
				opa = 33'(k0_q); opb = 33'(t0_q); base = p00_q; sub = 1'b1;
			end
			OP_P01_UPD: begin
				opa = 33'(k0_q); opb = 33'(t1_q); base = p01_q; sub = 1'b1;
			end
			OP_P10_UPD: begin
				opa = 33'(k1_q); opb = 33'(t0_q); base = p10_q; sub = 1'b1;
			end
			OP_P11_UPD: begin
				opa = 33'(k1_q); opb = 33'(t1_q); base = p11_q; sub = 1'b1;
			end
			OP_ANG_UPD: begin
				opa = 33'(k0_q); opb = 33'(err_q);
			end
			OP_BIAS_UPD: begin
				opa = 33'(k1_q); opb = 33'(err_q); base = bias_q;
			end
			default: begin
				opa = '0;
			end
		endcase
		rnd  = (prod_q + MUL_HALF) >>> FRAC_BITS;
		msat = sat32(68'(rnd));
		res  = sub ? sat32(68'(base) - 68'(msat)) : sat32(68'(base) + 68'(msat));
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aq_q      <= 17'd66;
			bq_q      <= 17'd66;
			r_q       <= 23'd327680;
			dt_q      <= 17'd262;
			acc_ofs_q <= 16'sd0;
			gyr_ofs_q <= 16'sd1;
			mode_q    <= 1'b0;
			lean_q    <= 24'sd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ANGLE_Q: aq_q      <= cfg_data[16:0];
				CFG_BIAS_Q:  bq_q      <= cfg_data[16:0];
				CFG_MEAS_R:  r_q       <= cfg_data[22:0];
				CFG_DT:      dt_q      <= cfg_data[16:0];
				CFG_ACC_OFS: acc_ofs_q <= cfg_data[15:0];
				CFG_GYR_OFS: gyr_ofs_q <= cfg_data[15:0];
				CFG_MODE:    mode_q    <= cfg_data[0];
				CFG_LEAN:    lean_q    <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ANG_PRED;
			ang_q       <= '0;
			bias_q      <= '0;
			p00_q       <= ONE_Q;
			p01_q       <= '0;
			p10_q       <= '0;
			p11_q       <= ONE_Q;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// hand over a finished word once the output register is free
			if (pend_q && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_RATE0;
					end
				end
				S_RATE0: begin
					state_q <= S_RATE1;
				end
				S_RATE1: begin
					op_q    <= OP_ANG_PRED;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					unique case (op_q)
						OP_ANG_PRED, OP_ANG_UPD: ang_q <= res;
						OP_P00_PRED, OP_P00_UPD: p00_q <= res;
						OP_P01_PRED, OP_P01_UPD: p01_q <= res;
						OP_P10_PRED, OP_P10_UPD: p10_q <= res;
						OP_P11_PRED, OP_P11_UPD: p11_q <= res;
						OP_BIAS_UPD:             bias_q <= res;
						default: ;
					endcase
					op_q <= op_t'(op_q + 4'd1);
					if (op_q == OP_P11_PRED) begin
						state_q <= S_PREPK;
					end else if (op_q == OP_BIAS_UPD) begin
						pend_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_PREPK: begin
					if (e_n != 0) begin
						state_q <= S_GAIN0;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_GAIN0: begin
					if (div_st.done) begin
						state_q <= S_GAIN1;
					end
				end
				S_GAIN1: begin
					if (div_st.done) begin
						state_q <= S_MUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			meas_q <= meas_n;
			hp_q   <= hp_n;
		end
		if (state_q == S_RATE0) begin
			qa_q <= qa_n;
			y_q  <= {rb_n, {(FRAC_BITS + 1){1'b0}}} + RATE_HALF;
		end
		if (state_q == S_RATE1) begin
			rate_q <= rate_n;
		end
		if (state_q == S_MUL) begin
			prod_q <= opa * opb;
		end
		if (state_q == S_PREPK) begin
			err_q <= sat32(68'(meas_q) - 68'(ang_q));
			e_q   <= e_n;
			t0_q  <= p00_q;
			t1_q  <= p01_q;
			k0_q  <= '0;
			k1_q  <= '0;
		end
		if (state_q == S_GAIN0 && div_st.done) begin
			k0_q <= div_q;
		end
		if (state_q == S_GAIN1 && div_st.done) begin
			k1_q <= div_q;
		end
		if (pend_q && (!out_valid_q || !out_stall)) begin
			fused_angle <= ang_q;
			angle_rate  <= sat32(68'(rate_q) - 68'(bias_q));
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_RATE0)
		else $error("accepted word did not start the rate scaling");

	a_div_done_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == S_GAIN0 || state_q == S_GAIN1)
		else $error("divider finished outside a division step");

	a_no_lost_word: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> state_q == S_IDLE && in_stall)
		else $error("pending result while sequencer busy");

	a_acc_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC |-> $past(state_q) == S_MUL)
		else $error("accumulate without a product");
`endif

endmodule

// ===== verif/tilt_angle_kalman_fusion_tb.sv =====
// Testbench for tilt_angle_kalman_fusion: drives accelerometer/gyro words, predicts the
// fused angle and corrected rate with a local fixed-point Kalman predictor, checks results.
// Depends on tkf_pkg (register indexes) and the tilt_angle_kalman_fusion RTL.
`timescale 1ns / 1ps

module tilt_angle_kalman_fusion_tb;
	import tkf_pkg::*;

	localparam int FB = 16;
	localparam longint Q1 = 64'sd1 << FB;
	localparam int LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] accel_z = '0;
	logic signed [15:0] gyro_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] fused_angle;
	logic signed [31:0] angle_rate;

	typedef struct {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
	} fusion_word_t;

	fusion_word_t expected_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit idling_on = 1'b1;

	// predictor copy of registers and filter state
	longint r_q_ang, r_q_bias, r_meas_r, r_dt, r_acc_ofs, r_gyr_ofs, r_mode, r_lean;
	longint est_angle, est_bias, p00, p01, p10, p11;

	tilt_angle_kalman_fusion i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) q--;
		return q;
	endfunction

	function automatic longint round_div(longint a, longint b);
		if (b < 0) begin
			a = -a;
			b = -b;
		end
		return floor_div(2 * a + b, 2 * b);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return clamp32(floor_div(a * b + (Q1 / 2), Q1));
	endfunction

	function automatic longint sx(longint v, int w);
		longint m;
		m = (64'sd1 <<< w) - 1;
		v = v & m;
		if (v[w-1]) return v - (64'sd1 <<< w);
		return v;
	endfunction

	task automatic filter_reset();
		r_q_ang = 66; r_q_bias = 66; r_meas_r = 327680; r_dt = 262;
		r_acc_ofs = 0; r_gyr_ofs = 1; r_mode = 0; r_lean = 0;
		est_angle = 0; est_bias = 0; p00 = Q1; p01 = 0; p10 = 0; p11 = Q1;
	endtask

	// run one predict/update step and queue the result
	task automatic predict_fusion(logic signed [15:0] az, logic signed [15:0] gy);
		longint d, g, meas, rate, err, e, k0, k1, t0, t1;
		fusion_word_t w;
		d = longint'(az) - r_acc_ofs;
		g = longint'(gy) - r_gyr_ofs;
		meas = floor_div(d * 180 * Q1 + 8192, 16384);
		meas += (r_mode == 0) ? r_lean : 25 * Q1;
		meas = clamp32(meas);
		rate = clamp32(round_div(g * 6 * Q1, 125));
		est_angle = clamp32(est_angle + qmul(clamp32(rate - est_bias), r_dt));
		p00 = clamp32(p00 + qmul(clamp32(r_q_ang - p01 - p10), r_dt));
		p01 = clamp32(p01 + qmul(-p11, r_dt));
		p10 = clamp32(p10 + qmul(-p11, r_dt));
		p11 = clamp32(p11 + qmul(r_q_bias, r_dt));
		err = clamp32(meas - est_angle);
		e = clamp32(r_meas_r + p00);
		if (e != 0) begin
			k0 = clamp32(round_div(p00 * Q1, e));
			k1 = clamp32(round_div(p10 * Q1, e));
		end else begin
			k0 = 0;
			k1 = 0;
		end
		t0 = p00;
		t1 = p01;
		p00 = clamp32(p00 - qmul(k0, t0));
		p01 = clamp32(p01 - qmul(k0, t1));
		p10 = clamp32(p10 - qmul(k1, t0));
		p11 = clamp32(p11 - qmul(k1, t1));
		est_angle = clamp32(est_angle + qmul(k0, err));
		est_bias = clamp32(est_bias + qmul(k1, err));
		w.angle = est_angle[31:0];
		w.rate = 32'(clamp32(rate - est_bias));
		expected_q.push_back(w);
	endtask

	// write one register while idle and mirror it
	task automatic write_reg(cfg_idx_t idx, longint value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[23:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ANGLE_Q: r_q_ang = value & 64'h1FFFF;
			CFG_BIAS_Q: r_q_bias = value & 64'h1FFFF;
			CFG_MEAS_R: r_meas_r = value & 64'h7FFFFF;
			CFG_DT: r_dt = value & 64'h1FFFF;
			CFG_ACC_OFS: r_acc_ofs = sx(value, 16);
			CFG_GYR_OFS: r_gyr_ofs = sx(value, 16);
			CFG_MODE: r_mode = value & 1;
			CFG_LEAN: r_lean = sx(value, 24);
			default: ;
		endcase
	endtask

	// send one word, with an optional random gap first; valid drops in the gap or in drain
	task automatic send_word(logic signed [15:0] az, logic signed [15:0] gy);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_z <= az;
		gyro_y <= gy;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_fusion(az, gy);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_regs(bit extreme);
		write_reg(CFG_ANGLE_Q, extreme ? 65536 : $urandom_range(0, 2000));
		write_reg(CFG_BIAS_Q, extreme ? 0 : $urandom_range(0, 2000));
		write_reg(CFG_MEAS_R, extreme ? $urandom_range(1, 2) * 2097152 :
			$urandom_range(1, 4194304));
		write_reg(CFG_DT, extreme ? $urandom_range(0, 1) * 65535 + 1 : $urandom_range(1, 6554));
		write_reg(CFG_ACC_OFS, $urandom_range(0, 65535));
		write_reg(CFG_GYR_OFS, $urandom_range(0, 65535));
		write_reg(CFG_MODE, $urandom_range(0, 1));
		write_reg(CFG_LEAN, longint'($urandom_range(0, 11796480)) - 5898240);
	endtask

	task automatic test_directed();
		send_word(16'sh7fff, 16'sh7fff);
		send_word(-16'sh8000, -16'sh8000);
		send_word(16'sd0, 16'sd0);
		send_word(16'sh0001, -16'sh0001);
		send_word(16'sh5555, 16'shaaaa);
		send_word(16'shaaaa, 16'sh5555);
		drain();
		write_reg(CFG_MODE, 1);
		send_word(16'sd0, 16'sd1);
		send_word(-16'sh8000, 16'sh7fff);
		drain();
		// extremes of registers: full lean, process noise and period of 1.0, smallest measurement noise
		write_reg(CFG_MODE, 0);
		write_reg(CFG_LEAN, 5898240);
		write_reg(CFG_ANGLE_Q, 65536);
		write_reg(CFG_BIAS_Q, 65536);
		write_reg(CFG_DT, 65536);
		write_reg(CFG_MEAS_R, 1);
		write_reg(CFG_ACC_OFS, 16'h8000);
		write_reg(CFG_GYR_OFS, 16'h7fff);
		repeat (6) send_word(16'sh7fff, -16'sh8000);
		drain();
		write_reg(CFG_LEAN, -5898240);
		write_reg(CFG_MEAS_R, 4194304);
		write_reg(CFG_ANGLE_Q, 0);
		write_reg(CFG_BIAS_Q, 0);
		write_reg(CFG_DT, 1);
		repeat (5) send_word(16'($urandom), 16'($urandom));
		drain();
	endtask

	task automatic test_random(int phases, int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			random_regs(ph % 4 == 0);
			for (int n = 0; n < per_phase; n++)
				send_word(16'($urandom), 16'($urandom));
			drain();
		end
	endtask

	task automatic test_no_idle();
		idling_on = 1'b0;
		repeat (100) send_word(16'($urandom), 16'($urandom));
		drain();
	endtask

	// random receiver stall bursts, only while idling_on is set
	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(1, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected word: angle %0d rate %0d", $time, fused_angle,
					angle_rate);
				errors++;
			end else begin
				fusion_word_t w;
				w = expected_q.pop_front();
				if (fused_angle !== w.angle) begin
					$display("%0t fused_angle expected %0d actual %0d", $time, w.angle,
						fused_angle);
					errors++;
				end
				if (angle_rate !== w.rate) begin
					$display("%0t angle_rate expected %0d actual %0d", $time, w.rate,
						angle_rate);
					errors++;
				end
			end
		end
	end

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > LIMIT) begin
			$display("tilt_angle_kalman_fusion regression: fail");
			$finish;
		end
	end

	initial begin
		filter_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(10, 100);
		test_no_idle();
		if (errors == 0 && expected_q.size() == 0) begin
			$display("tilt_angle_kalman_fusion regression: pass");
		end else begin
			$display("tilt_angle_kalman_fusion regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/tkf_pkg.sv
hw/rtl/tkf_div.sv
hw/rtl/tilt_angle_kalman_fusion.sv
verif/tilt_angle_kalman_fusion_tb.sv
